// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the line filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FLF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FLF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/flf_pkg.sv =====
// Types and constants of the mirrored-border line filter.
package flf_pkg;

   localparam int MAX_HALF_TAPS   = 12;
   localparam int SAMPLE_BITS     = 16;
   localparam int COEFF_BITS      = 16;
   localparam int COEFF_FRAC_BITS = 14;
   localparam int WIN_LEN         = 2 * MAX_HALF_TAPS + 1;
   localparam int PROD_BITS       = SAMPLE_BITS + COEFF_BITS;
   localparam int ACC_BITS        = PROD_BITS + $clog2(WIN_LEN);
   localparam int IDX_BITS        = $clog2(WIN_LEN);
   localparam int H_BITS          = 4;
   localparam int CNT_BITS        = 5;
   localparam int TAPS_PER_WORD   = 4;
   localparam int CSR_IDX_BITS    = 3;
   localparam int CSR_DATA_BITS   = 64;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_TAPS   = 3'd0;
   localparam int                      CSR_COEFF_FIRST = 1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [COEFF_BITS-1:0]  coeff_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef sample_type                    win_type [WIN_LEN];
   typedef coeff_type                     tap_type [WIN_LEN];

   typedef struct packed {
      logic last;
      logic err;
   } flag_type;

   typedef struct packed {
      sample_type sample_in;
      logic       line_end;
   } req_type;

   typedef struct packed {
      sample_type filtered;
      logic       line_done;
      logic       short_line_error;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_BITS-1:0]  reg_index;
      logic [CSR_DATA_BITS-1:0] wdata;
   } csr_type;

endpackage

// ===== hw/rtl/flf_stream_if.sv =====
// Valid/ready channel carrying one payload word.
interface flf_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fir_line_filter_reflect_border.sv =====
// Top level of the mirrored-border FIR line filter.
// Takes one sample per clock while the chain is ready and no end-of-line burst
// runs, and gives result j when sample j+H arrives, where the kernel has 2H+1
// taps. After the last sample of a line the input is held off while the
// remaining results of the line are issued from the stored window. Each result
// is built by a chain of 25 tap cells, one multiply-accumulate per cell, and
// leaves through an output register; stalls on the result side are absorbed
// by empty cells before the input stops.
`include "assert_macros.svh"

module fir_line_filter_reflect_border (
   input  logic          clock,
   input  logic          reset,
   flf_stream_if.sink    req_if,
   flf_stream_if.source  rsp_if,
   flf_stream_if.sink    csr_if
);
   import flf_pkg::*;

   localparam int CHAIN = WIN_LEN;

   // Configuration
   logic [H_BITS-1:0] half_taps_ff;
   tap_type           taps_ff;
   logic [H_BITS-1:0] h;

   // Window and line state
   win_type             window_ff, win_shift;
   logic [CNT_BITS-1:0] count_ff, count_in, newest;
   logic                burst_ff;
   logic [H_BITS-1:0]   burst_e_ff;

   // Job issue
   logic              req_acc, chain_rdy, short_line;
   logic              job_vld, job_end;
   logic [H_BITS-1:0] job_e;
   flag_type          job_flag;
   win_type           job_ops;

   // Chain links
   logic     vld_l  [CHAIN+1];
   logic     rdy_l  [CHAIN+1];
   acc_type  acc_l  [CHAIN+1];
   win_type  ops_l  [CHAIN+1];
   flag_type flag_l [CHAIN+1];

   // Register writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_taps_ff <= H_BITS'(1);
         for (int k = 0; k < WIN_LEN; k++) begin
            taps_ff[k] <= '0;
         end
      end else if (csr_if.valid) begin
         if (csr_if.data.reg_index == CSR_HALF_TAPS) begin
            half_taps_ff <= csr_if.data.wdata[H_BITS-1:0];
         end
         for (int k = 0; k < WIN_LEN; k++) begin
            if (csr_if.data.reg_index ==
                CSR_IDX_BITS'(k / TAPS_PER_WORD + CSR_COEFF_FIRST)) begin
               taps_ff[k] <= csr_if.data.wdata[(k % TAPS_PER_WORD) * COEFF_BITS +: COEFF_BITS];
            end
         end
      end
   end

   // Clamp H to its legal range
   always_comb begin
      if (half_taps_ff == '0) begin
         h = H_BITS'(1);
      end else if (half_taps_ff > H_BITS'(MAX_HALF_TAPS)) begin
         h = H_BITS'(MAX_HALF_TAPS);
      end else begin
         h = half_taps_ff;
      end
   end

   // Input handshake
   assign chain_rdy    = rdy_l[0];
   assign req_if.ready = chain_rdy && !burst_ff;
   assign req_acc      = req_if.valid && req_if.ready;

   // Count and window after this request
   always_comb begin
      count_in = (count_ff == '1) ? count_ff : count_ff + CNT_BITS'(1);
      newest   = count_in - CNT_BITS'(1);
      win_shift[0] = req_if.data.sample_in;
      for (int k = 1; k < WIN_LEN; k++) begin
         win_shift[k] = window_ff[k-1];
      end
   end

   assign short_line = {1'b0, count_in} < {1'b0, h, 1'b1};

   // Decide which result, if any, enters the chain
   always_comb begin
      job_vld  = 1'b0;
      job_end  = 1'b0;
      job_e    = h;
      job_flag = '0;
      if (burst_ff) begin
         job_vld       = 1'b1;
         job_end       = 1'b1;
         job_e         = burst_e_ff;
         job_flag.last = (burst_e_ff == '0);
      end else if (req_acc) begin
         if (!req_if.data.line_end) begin
            job_vld = ({1'b0, newest} >= {2'b0, h});
         end else if (short_line) begin
            job_vld       = 1'b1;
            job_flag.last = 1'b1;
            job_flag.err  = 1'b1;
         end else begin
            job_vld = 1'b1;
            job_end = 1'b1;
         end
      end
   end

   // Mirrored operand for each tap
   always_comb begin
      logic signed [7:0] kr_s, q_s, d_s;
      for (int k = 0; k < WIN_LEN; k++) begin
         kr_s = 8'(k) - $signed({4'b0, h});
         q_s  = $signed({3'b0, newest}) - $signed({4'b0, job_e}) + kr_s;
         if (!job_end && q_s < 0) begin
            d_s = $signed({3'b0, newest}) + q_s;
         end else if (job_end && kr_s > $signed({4'b0, job_e})) begin
            d_s = kr_s - $signed({4'b0, job_e});
         end else begin
            d_s = $signed({4'b0, job_e}) - kr_s;
         end
         if (!job_flag.err && (8'(k) <= {3'b0, h, 1'b0}) && d_s >= 0
             && d_s < 8'(WIN_LEN)) begin
            job_ops[k] = burst_ff ? window_ff[d_s[IDX_BITS-1:0]]
                                  : win_shift[d_s[IDX_BITS-1:0]];
         end else begin
            job_ops[k] = '0;
         end
      end
   end

   // Window, line count and end-of-line burst
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WIN_LEN; k++) begin
            window_ff[k] <= '0;
         end
         count_ff   <= '0;
         burst_ff   <= 1'b0;
         burst_e_ff <= '0;
      end else begin
         if (req_acc) begin
            window_ff <= win_shift;
            count_ff  <= req_if.data.line_end ? '0 : count_in;
            if (req_if.data.line_end && !short_line) begin
               burst_ff   <= 1'b1;
               burst_e_ff <= h - H_BITS'(1);
            end
         end else if (burst_ff && chain_rdy) begin
            if (burst_e_ff == '0) begin
               burst_ff <= 1'b0;
            end else begin
               burst_e_ff <= burst_e_ff - H_BITS'(1);
            end
         end
      end
   end

   // Tap cell chain
   assign vld_l[0]  = job_vld;
   assign acc_l[0]  = '0;
   assign ops_l[0]  = job_ops;
   assign flag_l[0] = job_flag;

   for (genvar k = 0; k < CHAIN; k++) begin : g_cell
      flf_cell #(.TAP(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .vld_in   (vld_l[k]),
         .rdy_out  (rdy_l[k]),
         .acc_in   (acc_l[k]),
         .ops_in   (ops_l[k]),
         .flag_in  (flag_l[k]),
         .tap_in   (taps_ff[k]),
         .vld_out  (vld_l[k+1]),
         .rdy_in   (rdy_l[k+1]),
         .acc_out  (acc_l[k+1]),
         .ops_out  (ops_l[k+1]),
         .flag_out (flag_l[k+1])
      );
   end

   flf_out u_out (
      .clock     (clock),
      .reset     (reset),
      .vld_in    (vld_l[CHAIN]),
      .rdy_out   (rdy_l[CHAIN]),
      .acc_in    (acc_l[CHAIN]),
      .flag_in   (flag_l[CHAIN]),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_if.data)
   );

   // Checks
   `FLF_ASSERT_IMP(a_burst_holds_input, clock, reset, burst_ff, !req_if.ready,
      "input taken during end-of-line burst")
   `FLF_ASSERT_NXT(a_burst_counts_down, clock, reset,
      burst_ff && chain_rdy && burst_e_ff != '0,
      burst_ff && burst_e_ff == $past(burst_e_ff) - H_BITS'(1),
      "burst countdown broken")
   `FLF_ASSERT_IMP(a_error_result, clock, reset,
      rsp_if.valid && rsp_if.data.short_line_error,
      rsp_if.data.line_done && rsp_if.data.filtered == '0,
      "short-line result not zero and final")
endmodule

// ===== hw/rtl/flf_cell.sv =====
// One tap cell: multiplies its operand by its tap and adds to the passing sum.
module flf_cell #(
   parameter int TAP = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                vld_in,
   output logic                rdy_out,
   input  flf_pkg::acc_type    acc_in,
   input  flf_pkg::win_type    ops_in,
   input  flf_pkg::flag_type   flag_in,
   input  flf_pkg::coeff_type  tap_in,
   output logic                vld_out,
   input  logic                rdy_in,
   output flf_pkg::acc_type    acc_out,
   output flf_pkg::win_type    ops_out,
   output flf_pkg::flag_type   flag_out
);
   import flf_pkg::*;

   logic                        vld_ff;
   acc_type                     acc_ff, acc_in_nxt;
   win_type                     ops_ff;
   flag_type                    flag_ff;
   logic signed [PROD_BITS-1:0] prod;

   // Stage moves when empty or when the next one takes its request
   assign rdy_out = !vld_ff || rdy_in;

   // Multiply-accumulate
   assign prod       = ops_in[TAP] * tap_in;
   assign acc_in_nxt = acc_in + ACC_BITS'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (rdy_out) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out && vld_in) begin
         acc_ff  <= acc_in_nxt;
         ops_ff  <= ops_in;
         flag_ff <= flag_in;
      end
   end

   assign vld_out  = vld_ff;
   assign acc_out  = acc_ff;
   assign ops_out  = ops_ff;
   assign flag_out = flag_ff;
endmodule

// ===== hw/rtl/flf_out.sv =====
// Output stage: rounds and saturates the sum, gives zero for a short-line error, and holds the result.
module flf_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               vld_in,
   output logic               rdy_out,
   input  flf_pkg::acc_type   acc_in,
   input  flf_pkg::flag_type  flag_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output flf_pkg::rsp_type   rsp_data
);
   import flf_pkg::*;

   localparam acc_type RND   = acc_type'(1) <<< (COEFF_FRAC_BITS - 1);
   localparam acc_type S_MAX = acc_type'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam acc_type S_MIN = -S_MAX - acc_type'(1);

   logic    vld_ff;
   rsp_type data_ff;
   acc_type rounded;
   sample_type sat;

   assign rdy_out = !vld_ff || rsp_ready;

   // Round half up, then clamp
   always_comb begin
      rounded = (acc_in + RND) >>> COEFF_FRAC_BITS;
      if (rounded > S_MAX) begin
         sat = S_MAX[SAMPLE_BITS-1:0];
      end else if (rounded < S_MIN) begin
         sat = S_MIN[SAMPLE_BITS-1:0];
      end else begin
         sat = rounded[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (rdy_out) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out && vld_in) begin
         data_ff.filtered         <= flag_in.err ? '0 : sat;
         data_ff.line_done        <= flag_in.last;
         data_ff.short_line_error <= flag_in.err;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp_data  = data_ff;
endmodule
